>>> hdl/png_scanline_unfilter_assert.svh
// Assertion macros used by the scanline unfilter RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Clocked check, off while reset is held.
`define PSU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("psu check failed");

// Clocked check that also runs during reset.
`define PSU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("psu check failed");

`endif

>>> hdl/psu_pkg.sv
// Shared constants for the PNG scanline unfilter.
// No dependencies; used by the interfaces and the top level.
package psu_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BPP      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_BYTES = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROWS     = 2'd2;

  // Row filter type codes
  localparam logic [ByteW-1:0] FILT_NONE  = 8'd0;
  localparam logic [ByteW-1:0] FILT_SUB   = 8'd1;
  localparam logic [ByteW-1:0] FILT_UP    = 8'd2;
  localparam logic [ByteW-1:0] FILT_AVG   = 8'd3;
  localparam logic [ByteW-1:0] FILT_PAETH = 8'd4;

endpackage

>>> hdl/psu_byte_if.sv
// Input byte channel of the scanline unfilter.
// Depends on psu_pkg.
interface psu_byte_if
  import psu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

>>> hdl/psu_result_if.sv
// Result channel of the scanline unfilter.
// Depends on psu_pkg.
interface psu_result_if
  import psu_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] pixel_byte;
  logic             row_end;
  logic             image_end;
  logic             bad_filter;

  modport source (output valid, output pixel_byte, output row_end, output image_end,
                  output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

>>> hdl/psu_cfg_if.sv
// Configuration write channel of the scanline unfilter.
// Depends on psu_pkg.
interface psu_cfg_if
  import psu_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module psu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> hdl/png_scanline_unfilter.sv
// PNG scanline reconstruction (None, Sub, Up, Average, Paeth), one byte per cycle.
// Depends on psu_pkg, the psu_*_if interfaces, psu_ram and the assertion header.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------------------
//  in_i     | in  | valid/ready      | stream_byte (filter type or filtered byte)
//  out_o    | out | valid/ready      | pixel_byte, row_end, image_end, bad_filter
//  cfg_i    | in  | valid/ready (=1) | index (0 bpp, 1 row_bytes, 2 image_rows), data
//
// One request is accepted per cycle. A sample byte enters the work register when it is
// accepted (line store read alongside) and moves on to the output register once that
// is free or being taken, where its result is offered. A filter type byte is consumed
// and gives no result. No clearing pass after reset.
// A request is taken whenever the work register is empty or moves on; with both
// registers full and the output not ready, the input stalls.
`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  psu_byte_if.sink         in_i,
  psu_result_if.source     out_o,
  psu_cfg_if.sink          cfg_i
);

  localparam int unsigned ColW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned LenW = ColW + 1;
  localparam int unsigned PixW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  bpp_q;
  logic [13:0] row_bytes_q;
  logic [15:0] image_rows_q;
  logic        cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= 4'd1;
      row_bytes_q  <= 14'd1;
      image_rows_q <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        CFG_BPP:       bpp_q        <= cfg_i.data[3:0];
        CFG_ROW_BYTES: row_bytes_q  <= cfg_i.data[13:0];
        CFG_ROWS:      image_rows_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Effective values: zero acts as one, oversize values clamp
  logic [3:0]      eff_bpp;
  logic [LenW-1:0] eff_len;
  logic [15:0]     eff_rows;

  always_comb begin
    if (bpp_q == 4'd0) begin
      eff_bpp = 4'd1;
    end else if (bpp_q > 4'(MAX_PIXEL_BYTES)) begin
      eff_bpp = 4'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = bpp_q;
    end
    if (row_bytes_q == 14'd0) begin
      eff_len = LenW'(1);
    end else if (32'(row_bytes_q) > 32'(MAX_ROW_BYTES)) begin
      eff_len = LenW'(MAX_ROW_BYTES);
    end else begin
      eff_len = LenW'(row_bytes_q);
    end
    eff_rows = (image_rows_q == 16'd0) ? 16'd1 : image_rows_q;
  end

  // ---------------------------------------------------------------------------
  // Row sequencing on the input side
  // ---------------------------------------------------------------------------
  logic             awaiting_q, awaiting_d;
  logic [ColW-1:0]  column_q, column_d;
  logic [15:0]      row_index_q, row_index_d;
  logic             first_row_q, first_row_d;
  logic [ByteW-1:0] row_filter_q;

  logic in_acc, filt_acc, samp_acc;
  logic rend, iend;
  logic s1_adv;
  logic s1_valid_q;

  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;
  assign filt_acc   = in_acc && awaiting_q;
  assign samp_acc   = in_acc && !awaiting_q;

  assign rend = (LenW'(column_q) + LenW'(1)) >= eff_len;
  assign iend = rend && ((17'(row_index_q) + 17'd1) >= 17'(eff_rows));

  always_comb begin
    awaiting_d  = awaiting_q;
    column_d    = column_q;
    row_index_d = row_index_q;
    first_row_d = first_row_q;
    if (filt_acc) begin
      awaiting_d = 1'b0;
      column_d   = '0;
    end else if (samp_acc) begin
      if (rend) begin
        awaiting_d = 1'b1;
        column_d   = '0;
        if (iend) begin
          row_index_d = 16'd0;
          first_row_d = 1'b1;
        end else begin
          row_index_d = row_index_q + 16'd1;
          first_row_d = 1'b0;
        end
      end else begin
        column_d = column_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q   <= 1'b1;
      column_q     <= '0;
      row_index_q  <= 16'd0;
      first_row_q  <= 1'b1;
      row_filter_q <= FILT_NONE;
    end else begin
      awaiting_q  <= awaiting_d;
      column_q    <= column_d;
      row_index_q <= row_index_d;
      first_row_q <= first_row_d;
      if (filt_acc) begin
        row_filter_q <= in_i.stream_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Work register: one sample with its row context; line store read alongside
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] s1_byte_q;
  logic [ByteW-1:0] s1_filter_q;
  logic [ColW-1:0]  s1_col_q;
  logic             s1_first_q, s1_rend_q, s1_iend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= samp_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (samp_acc) begin
      s1_byte_q   <= in_i.stream_byte;
      s1_filter_q <= row_filter_q;
      s1_col_q    <= column_q;
      s1_first_q  <= first_row_q;
      s1_rend_q   <= rend;
      s1_iend_q   <= iend;
    end
  end

  logic [ByteW-1:0] prior_rdata;
  logic [ByteW-1:0] recon;

  // Previous row. The write for a column always lands before the next row reads it.
  psu_ram #(
    .WIDTH (ByteW),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_row (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (recon),
    .re_i    (samp_acc),
    .raddr_i (column_q),
    .rdata_o (prior_rdata)
  );

  // Recent results (left) and recent above bytes (upper-left) of this row
  logic [ByteW-1:0] left_hist_q [MAX_PIXEL_BYTES];
  logic [ByteW-1:0] up_hist_q   [MAX_PIXEL_BYTES];

  logic [PixW-1:0]  hidx;
  logic             have_left;
  logic [ByteW-1:0] nb_a, nb_b, nb_c;
  logic             bad;

  // Paeth predictor: nearest of a, b, c to a+b-c; ties to a, then b
  function automatic logic [ByteW-1:0] paeth(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c);
    logic [ByteW-1:0] da, db;
    logic [9:0]       sab, c2, dc;
    da  = (b > c) ? (b - c) : (c - b);
    db  = (a > c) ? (a - c) : (c - a);
    sab = 10'(a) + 10'(b);
    c2  = {1'b0, c, 1'b0};
    dc  = (sab > c2) ? (sab - c2) : (c2 - sab);
    if ((da <= db) && (10'(da) <= dc)) begin
      return a;
    end else if (10'(db) <= dc) begin
      return b;
    end
    return c;
  endfunction

  always_comb begin
    logic [8:0] avg_sum;
    hidx      = PixW'(eff_bpp - 4'd1);
    have_left = s1_col_q >= ColW'(eff_bpp);
    nb_a      = have_left ? left_hist_q[hidx] : '0;
    nb_b      = s1_first_q ? '0 : prior_rdata;
    nb_c      = (have_left && !s1_first_q) ? up_hist_q[hidx] : '0;
    avg_sum   = 9'(nb_a) + 9'(nb_b);
    bad       = 1'b0;
    unique case (s1_filter_q)
      FILT_NONE:  recon = s1_byte_q;
      FILT_SUB:   recon = s1_byte_q + nb_a;
      FILT_UP:    recon = s1_byte_q + nb_b;
      FILT_AVG:   recon = s1_byte_q + avg_sum[8:1];
      FILT_PAETH: recon = s1_byte_q + paeth(nb_a, nb_b, nb_c);
      default: begin
        recon = s1_byte_q;
        bad   = 1'b1;
      end
    endcase
  end

  // Histories shift once per finished sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
        left_hist_q[i] <= '0;
        up_hist_q[i]   <= '0;
      end
    end else if (s1_adv) begin
      left_hist_q[0] <= recon;
      up_hist_q[0]   <= nb_b;
      for (int i = 1; i < int'(MAX_PIXEL_BYTES); i++) begin
        left_hist_q[i] <= left_hist_q[i-1];
        up_hist_q[i]   <= up_hist_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             out_rend_q, out_iend_q, out_bad_q;

  assign s1_adv = s1_valid_q && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_adv || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q <= recon;
      out_rend_q <= s1_rend_q;
      out_iend_q <= s1_iend_q;
      out_bad_q  <= bad;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.pixel_byte = out_byte_q;
  assign out_o.row_end    = out_rend_q;
  assign out_o.image_end  = out_iend_q;
  assign out_o.bad_filter = out_bad_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `PSU_ASSERT(a_img_end_on_row_end, clk_i, rst_ni,
              out_o.valid |-> (!out_o.image_end || out_o.row_end))
  `PSU_ASSERT(a_stall_holds_work, clk_i, rst_ni,
              (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_col_q)))
  `PSU_ASSERT(a_row_end_waits_filter, clk_i, rst_ni,
              (samp_acc && rend) |=> awaiting_q)
  `PSU_ASSERT(a_ready_low_only_full, clk_i, rst_ni,
              !in_i.ready |-> (s1_valid_q && out_valid_q && !out_o.ready))

endmodule
